// ----- rtl/ida_pkg.sv -----
// shared constants and types for the id allocation table
`default_nettype none
package ida_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W     = 31;
  localparam int HANDLE_W = 32;
  localparam int CTR_W    = ID_W + 1;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_PREV  = 3'd3;
  localparam logic [2:0] OP_NEXT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISS      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } ida_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } ida_entry_t;

endpackage
`default_nettype wire

// ----- rtl/ida_store.sv -----
// slot memory holding identifier and handle pairs, one write and one registered read port
`default_nettype none
module ida_store
  import ida_pkg::*;
(
  input  wire logic              clk,
  input  wire ida_wr_t           wr,
  input  wire logic [SLOT_W-1:0] rd_slot,
  output ida_entry_t             rd_data
);

  ida_entry_t mem [CAPACITY];
  ida_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= '{id: wr.id, handle: wr.handle};
    end
    rd_data_r <= mem[rd_slot];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/id_allocation_table.sv -----
// id allocation table: top level with scan sequencer and shared compare unit
//
// a table of up to 64 (identifier, handle) pairs. one transaction on the in_
// channel carries an opcode (allocate, get, free, previous, next), a query
// identifier and a handle; each gives exactly one transaction on the out_
// channel with a status, an identifier and a handle.
// allocate and the unused opcodes go straight to the finish state; out_valid
// rises when the result is loaded from there into the output register.
// get, free, prev and next walk the occupied slots through the single read
// port of the slot memory, one slot a cycle; a free that hits then reads the
// last entry and writes it into the freed slot.
// in_stall is high from acceptance until the result has been moved into the
// output register, so one transaction is in flight at a time and the next one
// can be taken in the same cycle that out_valid rises.
// if out_stall holds a result, the next finished result waits in the
// sequencer and in_stall stays high.
// reset (rst_n low, synchronous) empties the table, restarts the identifier
// counter at zero and drops out_valid; the slot memory is not cleared since
// only occupied slots are ever read.
`default_nettype none
module id_allocation_table
  import ida_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_opcode,
  input  wire logic [ID_W-1:0]     in_query_id,
  input  wire logic [HANDLE_W-1:0] in_entry_handle,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [ID_W-1:0]          out_result_id,
  output logic [HANDLE_W-1:0]      out_result_handle
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FREE_RD = 3'd2;
  localparam logic [2:0] S_FREE_WR = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [COUNT_W-1:0]  used_r, used_nxt;
  logic [CTR_W-1:0]    ctr_r, ctr_nxt;
  logic [COUNT_W-1:0]  idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   pend_slot_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [ID_W-1:0]     key_r, key_nxt;
  logic                found_r, found_nxt;
  logic [ID_W-1:0]     best_r, best_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [HANDLE_W-1:0] out_handle_r;

  logic              accept;
  logic              issue;
  logic              load_out;
  logic              is_eq, is_lt, is_gt, beats_best;
  logic [SLOT_W-1:0] rd_slot;
  ida_wr_t           wr;
  ida_entry_t        rd_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign issue    = (state_r == S_SCAN) && (idx_r < used_r);
  assign load_out = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  // shared compare unit on the entry coming out of the memory
  assign is_eq = (rd_data.id == key_r);
  assign is_lt = (rd_data.id < key_r);
  assign is_gt = (rd_data.id > key_r);
  assign beats_best = !found_r ||
                      ((op_r == OP_PREV) ? (rd_data.id > best_r) : (rd_data.id < best_r));

  assign rd_slot = (state_r == S_SCAN) ? idx_r[SLOT_W-1:0] : used_r[SLOT_W-1:0];

  always_comb begin
    wr = '0;
    if (accept && (in_opcode == OP_ALLOC) && (used_r != COUNT_W'(CAPACITY)) &&
        !ctr_r[CTR_W-1]) begin
      wr.en     = 1'b1;
      wr.slot   = used_r[SLOT_W-1:0];
      wr.id     = ctr_r[ID_W-1:0];
      wr.handle = in_entry_handle;
    end else if (state_r == S_FREE_WR) begin
      wr.en     = 1'b1;
      wr.slot   = slot_r;
      wr.id     = rd_data.id;
      wr.handle = rd_data.handle;
    end
  end

  ida_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_slot (rd_slot),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    ctr_nxt        = ctr_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    slot_nxt       = slot_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_handle_nxt = res_handle_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_opcode;
          key_nxt        = in_query_id;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          best_nxt       = '0;
          res_status_nxt = ST_MISS;
          res_id_nxt     = '0;
          res_handle_nxt = '0;
          if (in_opcode == OP_ALLOC) begin
            state_nxt = S_FINISH;
            if (used_r == COUNT_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else if (ctr_r[CTR_W-1]) begin
              res_status_nxt = ST_EXHAUSTED;
            end else begin
              res_status_nxt = ST_OK;
              res_id_nxt     = ctr_r[ID_W-1:0];
              used_nxt       = used_r + COUNT_W'(1);
              ctr_nxt        = ctr_r + CTR_W'(1);
            end
          end else if ((in_opcode == OP_GET) || (in_opcode == OP_FREE) ||
                       (in_opcode == OP_PREV) || (in_opcode == OP_NEXT)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt  = idx_r + COUNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && is_eq && (op_r == OP_GET)) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = rd_data.handle;
          pend_nxt       = 1'b0;
          state_nxt      = S_FINISH;
        end else if (pend_r && is_eq && (op_r == OP_FREE)) begin
          slot_nxt  = pend_slot_r;
          used_nxt  = used_r - COUNT_W'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_FREE_RD;
        end else begin
          if (pend_r && beats_best &&
              (((op_r == OP_PREV) && is_lt) || ((op_r == OP_NEXT) && is_gt))) begin
            found_nxt = 1'b1;
            best_nxt  = rd_data.id;
          end
          if (!issue && !pend_r) begin
            state_nxt = S_FINISH;
            if (found_r) begin
              res_status_nxt = ST_OK;
              res_id_nxt     = best_r;
            end
          end
        end
      end
      // last entry is being read into the memory output register
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: begin
        res_status_nxt = ST_OK;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      ctr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ctr_r       <= ctr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_slot_r  <= idx_r[SLOT_W-1:0];
    slot_r       <= slot_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_handle_r <= res_handle_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_handle_r <= res_handle_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_handle = out_handle_r;

endmodule
`default_nettype wire

// ----- rtl/ida_checker.sv -----
// port-level checks for the id allocation table, bound to the top level
`default_nettype none
module ida_checker
  import ida_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [1:0]          out_status,
  input wire logic [ID_W-1:0]     out_result_id,
  input wire logic [HANDLE_W-1:0] out_result_handle
);

  // a failed transaction carries no identifier and no handle
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_result_id == '0) && (out_result_handle == '0)))
    else $error("failed transaction carries a non-zero payload");

  // only get returns a handle, and get returns no identifier
  a_handle_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_handle != '0)) |-> (out_result_id == '0))
    else $error("result carries both an identifier and a handle");

  // one transaction at a time: busy straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_result_id) &&
       $stable(out_result_handle)))
    else $error("stalled result changed");

endmodule

bind id_allocation_table ida_checker u_ida_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_result_id     (out_result_id),
  .out_result_handle (out_result_handle)
);
`default_nettype wire
